### rtl/bvg_pkg.sv
`default_nettype none
// Package for the battery voltage gauge: widths and the request and response
// words of the shared bit-serial divider. No dependencies.
package bvg_pkg;

  localparam int unsigned DIV_W = 32;
  localparam int unsigned DSR_W = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage : bvg_pkg
`default_nettype wire

### rtl/bvg_div.sv
`default_nettype none
// Restoring radix-2 divider for a DIV_W-bit dividend, one quotient bit per cycle.
// Depends on bvg_pkg for widths and the request and response structs.
module bvg_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bvg_pkg::div_req_t req_i,
  output bvg_pkg::div_rsp_t      rsp_o
);
  import bvg_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DSR_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DSR_W-1:0]     dsr_q, dsr_d;
  logic [DSR_W:0]       trial;
  logic                 fits;

  always_comb begin
    trial  = {rem_q, quo_q[DIV_W-1]};
    fits   = trial >= {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_W);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? DSR_W'(trial - {1'b0, dsr_q}) : trial[DSR_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule : bvg_div
`default_nettype wire

### rtl/battery_voltage_gauge.sv
`default_nettype none
// Battery voltage gauge: averages converter samples and turns them into a
// battery voltage and a charge percent. Depends on bvg_pkg and bvg_div.
//
// Input words (s_axis) carry an action in tuser: update request, good sample
// or failed conversion. A request starts a burst when a converter is attached
// and no measurement exists yet or the update interval has run out; detached,
// it yields an error word, otherwise the held snapshot; in a burst, nothing.
// Samples and failures count only in a burst. Words are taken only when idle.
// The word that closes a burst starts the end-of-burst arithmetic: up to four
// divisions on the shared bit-serial divider (average, converter millivolts,
// battery millivolts, percent) with multiply steps between them, then the
// result word. Words that only reply go straight to the emit step.
// Result words (m_axis) sit in an output register; while the receiver stalls
// the block keeps taking words that give no result, and holds in its emit
// step once a second result is due. Reset restores the register defaults,
// clears the snapshot and counters and drops any pending word.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i.
module battery_voltage_gauge #(
  parameter int unsigned SAMPLES_PER_UPDATE = 8,
  parameter int unsigned ADC_BITS           = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_idx_i,
  input  wire logic [31:0]   cfg_wdata_i,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // now_ms[31:0], sample[43:32], fail_status[45:44], zero pad
  input  wire logic [47:0]   s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]    s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // raw_average[11:0], adc_mv[24:12], vbat_mv[40:25], percent[47:41],
  // update_count[79:48], error_count[111:80], last_status[113:112], zero pad
  output logic [119:0]       m_axis_tdata,
  // fresh[0], valid_res[1]
  output logic [1:0]         m_axis_tuser
);
  import bvg_pkg::*;

  localparam int unsigned CNT_W = $clog2(SAMPLES_PER_UPDATE + 1);
  localparam int unsigned SUM_W = 12 + $clog2(SAMPLES_PER_UPDATE);
  localparam logic [DSR_W-1:0] FULL_SCALE = DSR_W'((1 << ADC_BITS) - 1);

  localparam logic [1:0] ACT_REQ    = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_FAIL   = 2'd2;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_ERR = 2'd1;

  localparam logic [2:0] REG_ATTACHED = 3'd0;
  localparam logic [2:0] REG_INTERVAL = 3'd1;
  localparam logic [2:0] REG_REF      = 3'd2;
  localparam logic [2:0] REG_TOP      = 3'd3;
  localparam logic [2:0] REG_BOTTOM   = 3'd4;
  localparam logic [2:0] REG_EMPTY    = 3'd5;
  localparam logic [2:0] REG_FULL     = 3'd6;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_AVG_DIV = 4'd1;
  localparam logic [3:0] ST_ADC_MUL = 4'd2;
  localparam logic [3:0] ST_ADC_DIV = 4'd3;
  localparam logic [3:0] ST_BAT_MUL = 4'd4;
  localparam logic [3:0] ST_BAT_DIV = 4'd5;
  localparam logic [3:0] ST_PCT_MUL = 4'd6;
  localparam logic [3:0] ST_PCT_DIV = 4'd7;
  localparam logic [3:0] ST_EMIT    = 4'd8;

  // configuration
  logic        attached_q;
  logic [31:0] interval_q;
  logic [12:0] ref_q;
  logic [15:0] top_q;
  logic [15:0] bottom_q;
  logic [15:0] empty_q;
  logic [15:0] full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attached_q <= 1'b0;
      interval_q <= 32'd1000;
      ref_q      <= 13'd3300;
      top_q      <= 16'd2200;
      bottom_q   <= 16'd1000;
      empty_q    <= 16'd3300;
      full_q     <= 16'd4200;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ATTACHED: attached_q <= cfg_wdata_i[0];
        REG_INTERVAL: interval_q <= cfg_wdata_i;
        REG_REF:      ref_q      <= cfg_wdata_i[12:0];
        REG_TOP:      top_q      <= cfg_wdata_i[15:0];
        REG_BOTTOM:   bottom_q   <= cfg_wdata_i[15:0];
        REG_EMPTY:    empty_q    <= cfg_wdata_i[15:0];
        REG_FULL:     full_q     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // state
  logic [3:0]       state_q, state_d;
  logic             start_q, start_d;
  logic             in_burst_q, in_burst_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]      last_q, last_d;
  logic             fresh_q, fresh_d;
  logic             snap_valid_q, snap_valid_d;
  logic [11:0]      snap_raw_q, snap_raw_d;
  logic [12:0]      snap_adc_q, snap_adc_d;
  logic [15:0]      snap_bat_q, snap_bat_d;
  logic [6:0]       snap_pct_q, snap_pct_d;
  logic [31:0]      measure_q, measure_d;
  logic [31:0]      failure_q, failure_d;
  logic [1:0]       status_q, status_d;
  logic             m_valid_q, m_valid_d;
  logic [119:0]     m_data_q, m_data_d;
  logic [1:0]       m_user_q, m_user_d;
  logic [31:0]      prod_q, prod_d;
  logic [16:0]      topbot_q, topbot_d;

  logic             accept;
  logic [1:0]       action;
  logic [31:0]      now_ms;
  logic [11:0]      sample;
  logic [1:0]       fail_status;
  logic [CNT_W-1:0] cnt_inc;
  logic [31:0]      elapsed;
  logic [15:0]      span;
  logic [15:0]      excess;
  logic [16:0]      mul_a;
  logic [16:0]      mul_b;
  logic [33:0]      mul_p;
  logic             div_done;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign action        = s_axis_tuser;
  assign now_ms        = s_axis_tdata[31:0];
  assign sample        = s_axis_tdata[43:32];
  assign fail_status   = s_axis_tdata[45:44];
  assign cnt_inc       = cnt_q + CNT_W'(1);
  assign elapsed       = now_ms - last_q;
  assign span          = full_q - empty_q;
  assign excess        = snap_bat_q - empty_q;
  assign div_done      = div_rsp.done && !start_q;

  always_comb begin
    unique case (state_q)
      ST_ADC_MUL: begin
        mul_a = 17'(snap_raw_q);
        mul_b = 17'(ref_q);
      end
      ST_BAT_MUL: begin
        mul_a = 17'(snap_adc_q);
        mul_b = topbot_q;
      end
      ST_PCT_MUL: begin
        mul_a = 17'(excess);
        mul_b = 17'd100;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    div_req.start = start_q;
    unique case (state_q)
      ST_AVG_DIV: begin
        div_req.dividend = DIV_W'(sum_q) + DIV_W'(cnt_q >> 1);
        div_req.divisor  = DSR_W'(cnt_q);
      end
      ST_ADC_DIV: begin
        div_req.dividend = prod_q + DIV_W'(FULL_SCALE >> 1);
        div_req.divisor  = FULL_SCALE;
      end
      ST_BAT_DIV: begin
        div_req.dividend = prod_q + DIV_W'(bottom_q >> 1);
        div_req.divisor  = bottom_q;
      end
      ST_PCT_DIV: begin
        div_req.dividend = prod_q + DIV_W'(span >> 1);
        div_req.divisor  = span;
      end
      default: begin
        div_req.dividend = '0;
        div_req.divisor  = '0;
      end
    endcase
  end

  bvg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d      = state_q;
    start_d      = 1'b0;
    in_burst_d   = in_burst_q;
    sum_d        = sum_q;
    cnt_d        = cnt_q;
    last_d       = last_q;
    fresh_d      = fresh_q;
    snap_valid_d = snap_valid_q;
    snap_raw_d   = snap_raw_q;
    snap_adc_d   = snap_adc_q;
    snap_bat_d   = snap_bat_q;
    snap_pct_d   = snap_pct_q;
    measure_d    = measure_q;
    failure_d    = failure_q;
    status_d     = status_q;
    prod_d       = prod_q;
    topbot_d     = topbot_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;
    m_user_d     = m_user_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action)
            ACT_REQ: begin
              if (!in_burst_q) begin
                if (!attached_q) begin
                  snap_valid_d = 1'b0;
                  status_d     = STAT_ERR;
                  fresh_d      = 1'b0;
                  state_d      = ST_EMIT;
                end else if (measure_q != '0 && elapsed < interval_q) begin
                  fresh_d = 1'b0;
                  state_d = ST_EMIT;
                end else begin
                  in_burst_d = 1'b1;
                  sum_d      = '0;
                  cnt_d      = '0;
                  last_d     = now_ms;
                end
              end
            end
            ACT_SAMPLE: begin
              if (in_burst_q) begin
                sum_d = sum_q + SUM_W'(sample);
                cnt_d = cnt_inc;
                if (cnt_inc == CNT_W'(SAMPLES_PER_UPDATE)) begin
                  in_burst_d = 1'b0;
                  status_d   = STAT_OK;
                  fresh_d    = 1'b1;
                  start_d    = 1'b1;
                  state_d    = ST_AVG_DIV;
                end
              end
            end
            ACT_FAIL: begin
              if (in_burst_q) begin
                in_burst_d = 1'b0;
                failure_d  = failure_q + 32'd1;
                status_d   = (fail_status == STAT_OK) ? STAT_ERR : fail_status;
                if (cnt_q == '0) begin
                  snap_valid_d = 1'b0;
                  fresh_d      = 1'b0;
                  state_d      = ST_EMIT;
                end else begin
                  fresh_d = 1'b1;
                  start_d = 1'b1;
                  state_d = ST_AVG_DIV;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_AVG_DIV: begin
        if (div_done) begin
          snap_raw_d = (|div_rsp.quotient[DIV_W-1:12]) ? 12'hFFF
                                                       : div_rsp.quotient[11:0];
          state_d    = ST_ADC_MUL;
        end
      end
      ST_ADC_MUL: begin
        prod_d   = mul_p[31:0];
        topbot_d = 17'(top_q) + 17'(bottom_q);
        start_d  = 1'b1;
        state_d  = ST_ADC_DIV;
      end
      ST_ADC_DIV: begin
        if (div_done) begin
          snap_adc_d = (|div_rsp.quotient[DIV_W-1:13]) ? 13'h1FFF
                                                       : div_rsp.quotient[12:0];
          if (bottom_q == '0) begin
            snap_bat_d = 16'hFFFF;
            state_d    = ST_PCT_MUL;
          end else begin
            state_d = ST_BAT_MUL;
          end
        end
      end
      ST_BAT_MUL: begin
        prod_d  = mul_p[31:0];
        start_d = 1'b1;
        state_d = ST_BAT_DIV;
      end
      ST_BAT_DIV: begin
        if (div_done) begin
          snap_bat_d = (|div_rsp.quotient[DIV_W-1:16]) ? 16'hFFFF
                                                       : div_rsp.quotient[15:0];
          state_d    = ST_PCT_MUL;
        end
      end
      ST_PCT_MUL: begin
        if (snap_bat_q <= empty_q || snap_bat_q >= full_q) begin
          snap_pct_d   = (snap_bat_q <= empty_q) ? 7'd0 : 7'd100;
          measure_d    = measure_q + 32'd1;
          snap_valid_d = 1'b1;
          state_d      = ST_EMIT;
        end else begin
          prod_d  = mul_p[31:0];
          start_d = 1'b1;
          state_d = ST_PCT_DIV;
        end
      end
      ST_PCT_DIV: begin
        if (div_done) begin
          snap_pct_d   = div_rsp.quotient[6:0];
          measure_d    = measure_q + 32'd1;
          snap_valid_d = 1'b1;
          state_d      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {6'd0, status_q, failure_q, measure_q, snap_pct_q,
                       snap_bat_q, snap_adc_q, snap_raw_q};
          m_user_d  = {snap_valid_q, fresh_q};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      start_q      <= 1'b0;
      in_burst_q   <= 1'b0;
      sum_q        <= '0;
      cnt_q        <= '0;
      last_q       <= '0;
      fresh_q      <= 1'b0;
      snap_valid_q <= 1'b0;
      snap_raw_q   <= '0;
      snap_adc_q   <= '0;
      snap_bat_q   <= '0;
      snap_pct_q   <= '0;
      measure_q    <= '0;
      failure_q    <= '0;
      status_q     <= STAT_OK;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      start_q      <= start_d;
      in_burst_q   <= in_burst_d;
      sum_q        <= sum_d;
      cnt_q        <= cnt_d;
      last_q       <= last_d;
      fresh_q      <= fresh_d;
      snap_valid_q <= snap_valid_d;
      snap_raw_q   <= snap_raw_d;
      snap_adc_q   <= snap_adc_d;
      snap_bat_q   <= snap_bat_d;
      snap_pct_q   <= snap_pct_d;
      measure_q    <= measure_d;
      failure_q    <= failure_d;
      status_q     <= status_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    topbot_q <= topbot_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule : battery_voltage_gauge
`default_nettype wire
